@@ hdl/cwpm_pkg.sv @@
// Shared widths, defaults and reset values for the causal weighted prefix mean core.
`default_nettype none

package cwpm_pkg;

	localparam int DIM_DEFAULT = 64;

	localparam int WEIGHT_W = 17;
	localparam int VALUE_W  = 16;
	localparam int INDEX_W  = 6;
	localparam int EPS_W    = 16;
	localparam int MEAN_W   = 16;

	localparam int TOTAL_W  = 32;
	localparam int SUM_W    = 48;
	localparam int PROD_W   = WEIGHT_W + 1 + VALUE_W;
	localparam int NUM_W    = SUM_W + 2;
	localparam int QUO_W    = 16;

	localparam int S_TDATA_W = ((WEIGHT_W + VALUE_W + INDEX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((MEAN_W + 7) / 8) * 8;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

	localparam logic [MEAN_W-1:0] MEAN_POS_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
	localparam logic [MEAN_W-1:0] MEAN_NEG_MAX = {1'b1, {(MEAN_W-1){1'b0}}};

	typedef logic [3:0] state_t;

endpackage

`default_nettype wire

@@ hdl/causal_weighted_prefix_mean_core.sv @@
// Causal weighted prefix mean core: per-element weighted running sums divided by the weight total.
//
// Each input transfer carries one value element of a token. Element 0 adds the token weight to
// the running weight total and latches the divisor (total + epsilon) for the whole token; each
// element then updates its own 48-bit weighted sum in an internal memory and returns the sum
// divided by the divisor as a rounded, saturated Q8.8 mean. One item is in flight at a time: an
// in-range element passes memory read, multiply, accumulate, magnitude, numerator, range check,
// 16 steps of the restoring divider and output load, and skips the divider when the divisor is
// zero. The core can take the next item in the cycle in which the result is offered. An element
// index at or beyond DIM goes straight to output load, returns 0 and changes neither the sums
// nor the weight total. The result waits in an output register, so the next item is accepted
// while it is not yet taken; a later result stalls in its last step until that register frees.
// The sums are not cleared by reset; a stream's first token overwrites them.
`default_nettype none

module causal_weighted_prefix_mean_core
	import cwpm_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire [EPS_W-1:0]        cfg_wr_data,   // epsilon
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire [S_TDATA_W-1:0]    s_tdata,       // weight[16:0], value[32:17], element_index[38:33]
	input  wire                    s_tuser,       // new_stream
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata        // mean_out[15:0]
);

	localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int RESTW = TOTAL_W + 2;
	localparam int CNT_W = $clog2(QUO_W);

	localparam state_t ST_IDLE = 4'd0;
	localparam state_t ST_READ = 4'd1;
	localparam state_t ST_ACC  = 4'd2;
	localparam state_t ST_MAG  = 4'd3;
	localparam state_t ST_NUM  = 4'd4;
	localparam state_t ST_CHK  = 4'd5;
	localparam state_t ST_DIV  = 4'd6;
	localparam state_t ST_FIN  = 4'd7;

	logic [SUM_W-1:0] mem [DIM];

	state_t                 state_q;
	logic [EPS_W-1:0]       eps_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [TOTAL_W-1:0]     recip_q;
	logic                   first_q;
	logic                   seen_q;
	logic                   m_tvalid_q;
	logic [MEAN_W-1:0]      m_data_q;

	logic [WEIGHT_W-1:0]    w_q;
	logic signed [VALUE_W-1:0] v_q;
	logic [AW-1:0]          addr_q;
	logic                   head_q;
	logic                   zero_q;
	logic [SUM_W-1:0]       rd_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       mag_q;
	logic                   neg_q;
	logic [NUM_W-1:0]       num_q;
	logic                   big_q;
	logic [RESTW-1:0]       rem_q;
	logic [QUO_W-1:0]       lo_q;
	logic [QUO_W-1:0]       quo_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [WEIGHT_W-1:0]    in_w;
	logic [VALUE_W-1:0]     in_v;
	logic [INDEX_W-1:0]     in_idx;
	logic                   in_range;
	logic                   accept;
	logic [TOTAL_W:0]       tot_add;
	logic [TOTAL_W:0]       rcp_add;
	logic signed [SUM_W:0]  acc_add;
	logic [SUM_W-1:0]       acc_sat;
	logic [SUM_W-1:0]       sum_next;
	logic [NUM_W-1:0]       div_lim;
	logic [RESTW:0]         rem_ext;
	logic [RESTW:0]         dvs_ext;
	logic                   rem_ge;
	logic [MEAN_W-1:0]      mean;
	logic                   out_free;

	assign in_w   = s_tdata[WEIGHT_W-1:0];
	assign in_v   = s_tdata[WEIGHT_W+VALUE_W-1:WEIGHT_W];
	assign in_idx = s_tdata[WEIGHT_W+VALUE_W+INDEX_W-1:WEIGHT_W+VALUE_W];
	assign in_range = 32'(in_idx) < 32'(DIM);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_data_q);
	assign out_free = !m_tvalid_q || m_tready;

	assign tot_add = {1'b0, total_q} + (TOTAL_W+1)'(in_w);
	assign rcp_add = {1'b0, total_q} + (TOTAL_W+1)'(eps_q);

	assign acc_add  = $signed({rd_q[SUM_W-1], rd_q}) + (SUM_W+1)'(prod_q);
	always_comb begin
		if (acc_add[SUM_W] != acc_add[SUM_W-1]) begin
			acc_sat = acc_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			acc_sat = acc_add[SUM_W-1:0];
		end
	end
	assign sum_next = first_q ? SUM_W'(prod_q) : acc_sat;

	assign div_lim = NUM_W'({recip_q, 17'b0});
	assign rem_ext = {rem_q, lo_q[QUO_W-1]};
	assign dvs_ext = (RESTW+1)'({recip_q, 1'b0});
	assign rem_ge  = rem_ext >= dvs_ext;

	always_comb begin
		if (zero_q) begin
			mean = '0;
		end else if (big_q) begin
			mean = neg_q ? MEAN_NEG_MAX : MEAN_POS_MAX;
		end else if (neg_q) begin
			mean = (quo_q > QUO_W'(MEAN_NEG_MAX)) ? MEAN_NEG_MAX : MEAN_W'(-quo_q);
		end else begin
			mean = (quo_q > QUO_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX : MEAN_W'(quo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= mem[addr_q];
		end
		if (state_q == ST_ACC) begin
			mem[addr_q] <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q    <= in_w;
			v_q    <= $signed(in_v);
			addr_q <= AW'(in_idx);
			head_q <= (in_idx == '0);
		end
		if (state_q == ST_READ) begin
			prod_q <= $signed({1'b0, w_q}) * v_q;
		end
		if (state_q == ST_ACC) begin
			sum_q <= sum_next;
		end
		if (state_q == ST_MAG) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
		end
		if (state_q == ST_NUM) begin
			num_q <= {1'b0, mag_q, 1'b0} + NUM_W'(recip_q);
		end
		if (state_q == ST_CHK) begin
			big_q <= num_q >= div_lim;
			rem_q <= num_q[NUM_W-1:QUO_W];
			lo_q  <= num_q[QUO_W-1:0];
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_ge ? RESTW'(rem_ext - dvs_ext) : RESTW'(rem_ext);
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			eps_q      <= EPS_RESET;
			total_q    <= '0;
			recip_q    <= '0;
			first_q    <= 1'b1;
			seen_q     <= 1'b0;
			zero_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				eps_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						zero_q <= !in_range;
						if (in_range && in_idx == '0) begin
							seen_q <= 1'b1;
							if (s_tuser || !seen_q) begin
								first_q <= 1'b1;
								total_q <= TOTAL_W'(in_w);
							end else begin
								first_q <= 1'b0;
								total_q <= tot_add[TOTAL_W] ? '1 : tot_add[TOTAL_W-1:0];
							end
						end
						state_q <= in_range ? ST_READ : ST_FIN;
					end
				end
				ST_READ: begin
					if (head_q) begin
						recip_q <= rcp_add[TOTAL_W] ? '1 : rcp_add[TOTAL_W-1:0];
					end
					state_q <= ST_ACC;
				end
				ST_ACC: state_q <= ST_MAG;
				ST_MAG: state_q <= ST_NUM;
				ST_NUM: state_q <= ST_CHK;
				ST_CHK: begin
					zero_q  <= (recip_q == '0);
					state_q <= (recip_q == '0) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= mean;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Testbench for the causal weighted prefix mean core: directed and random streams against a predictor.
`timescale 1ns / 1ps

module tb
	import cwpm_pkg::*;
();

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [EPS_W-1:0]     cfg_wr_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // weight[16:0], value[32:17], element_index[38:33]
	logic                 s_tuser = 1'b0; // new_stream
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // mean_out[15:0]

	causal_weighted_prefix_mean_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;

	// predictor state
	bit [EPS_W-1:0]   eps_q = EPS_RESET;
	bit [TOTAL_W-1:0] weight_total = '0;
	bit [TOTAL_W-1:0] divisor = '0;
	longint           wsum [DIM_DEFAULT];
	bit [DIM_DEFAULT-1:0] written = '0;
	bit               in_first = 1'b1;
	bit               seen = 1'b0;

	logic [MEAN_W-1:0] pending_means [$];
	logic [MEAN_W-1:0] want;
	int mismatches = 0;
	int items_sent = 0;
	bit calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("causal_weighted_prefix_mean_core: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit [WEIGHT_W-1:0] rand_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 18) return 17'd65536;
		if (r < 28) return 17'($urandom_range(65537, 131071));
		if (r < 38) return 17'($urandom_range(1, 16));
		return 17'($urandom_range(0, 65536));
	endfunction

	function automatic bit [VALUE_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return 16'h7FFF;
		if (r < 12) return 16'h8000;
		return 16'($urandom);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 6);
		if (r < 93) return $urandom_range(7, 20);
		return $urandom_range(21, DIM_DEFAULT);
	endfunction

	// true when this item would accumulate onto a sum never written since reset
	function automatic bit hits_unwritten(bit [INDEX_W-1:0] idx, bit ns);
		bit ft;
		ft = (idx == 0) ? (ns || !seen) : in_first;
		return !ft && !written[idx];
	endfunction

	function automatic logic [MEAN_W-1:0] predict_mean(bit [WEIGHT_W-1:0] w,
		bit signed [VALUE_W-1:0] v, bit [INDEX_W-1:0] idx, bit ns);
		longint prod;
		longint acc;
		longint unsigned s;
		longint unsigned mag;
		longint unsigned q;
		if (idx == 0) begin
			if (ns || !seen) begin
				in_first = 1'b1;
				weight_total = 32'(w);
			end else begin
				in_first = 1'b0;
				s = 64'(weight_total) + 64'(w);
				weight_total = (s > 64'hFFFF_FFFF) ? '1 : 32'(s);
			end
			seen = 1'b1;
			s = 64'(weight_total) + 64'(eps_q);
			divisor = (s > 64'hFFFF_FFFF) ? '1 : 32'(s);
		end
		prod = longint'(w) * longint'(v);
		if (in_first) begin
			acc = prod;
		end else begin
			acc = wsum[idx] + prod;
			if (acc > SUM_HI) acc = SUM_HI;
			if (acc < SUM_LO) acc = SUM_LO;
		end
		wsum[idx] = acc;
		written[idx] = 1'b1;
		if (divisor == 0) return '0;
		mag = (acc < 0) ? 64'(-acc) : 64'(acc);
		q = (2 * mag + 64'(divisor)) / (2 * 64'(divisor));
		if (acc < 0) return (q > 32768) ? MEAN_NEG_MAX : 16'(-q);
		return (q > 32767) ? MEAN_POS_MAX : 16'(q);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(bit [WEIGHT_W-1:0] w, bit [VALUE_W-1:0] v,
		bit [INDEX_W-1:0] idx, bit ns);
		int gap;
		gap = pick_gap();
		if (hits_unwritten(idx, ns)) idx = '0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = S_TDATA_W'({idx, v, w});
		s_tuser = ns;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_means.push_back(predict_mean(w, v, idx, ns));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_token(bit ns, int len);
		bit [WEIGHT_W-1:0] w;
		int pre;
		int i;
		pre = 0;
		while (pre < DIM_DEFAULT && written[pre]) pre++;
		if (!ns && seen && len > pre) len = pre;
		w = rand_weight();
		for (i = 0; i < len; i++)
			send_item(w, rand_value(), INDEX_W'(i), (i == 0) ? ns : 1'($urandom));
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending_means.size() != 0) @(negedge clk);
	endtask

	task automatic set_epsilon(bit [EPS_W-1:0] e);
		drain();
		repeat (25) @(negedge clk);
		cfg_wr_data = e;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		eps_q = e;
	endtask

	// elements ahead of any token, implicit first token, stream flag off element 0
	task automatic test_reset_start();
		send_item(17'd65536, 16'h7FFF, 6'd5, 1'b0);
		send_item(17'd65536, 16'h7FFF, 6'd0, 1'b0);
		send_item(17'd65536, 16'h8000, 6'd1, 1'b1);
		send_item(17'd65536, 16'h8000, 6'd63, 1'b0);
	endtask

	task automatic test_zero_divisor();
		set_epsilon('0);
		send_item('0, 16'h7FFF, 6'd0, 1'b1);
		send_item('0, 16'h8000, 6'd1, 1'b0);
		send_item('0, 16'h0100, 6'd2, 1'b0);
		send_item(17'h1FFFF, 16'h7FFF, 6'd0, 1'b0);
		send_item(17'h1FFFF, 16'h8000, 6'd1, 1'b0);
		send_item(17'h1FFFF, 16'h0001, 6'd2, 1'b0);
	endtask

	// sums left over from an earlier stream drive the mean into saturation
	task automatic test_skipped_entries();
		int i;
		for (i = 0; i < 4; i++) send_item(17'd65536, 16'h7FFF, 6'(i), i == 0);
		send_item(17'd1, '0, 6'd0, 1'b1);
		for (i = 0; i < 4; i++) send_item(17'd1, 16'h0001, 6'(i), 1'b0);
		for (i = 0; i < 2; i++) send_item(17'd65536, 16'h8000, 6'(i), i == 0);
		send_item(17'd1, '0, 6'd0, 1'b1);
		for (i = 0; i < 2; i++) send_item(17'd1, 16'hFFFF, 6'(i), 1'b0);
	endtask

	// half-way quotients round away from zero
	task automatic test_rounding();
		send_item(17'd2, 16'h0001, 6'd0, 1'b1);
		send_item(17'd2, 16'hFFFF, 6'd1, 1'b0);
		send_item(17'd2, 16'h0000, 6'd0, 1'b0);
		send_item(17'd2, 16'h0000, 6'd1, 1'b0);
	endtask

	task automatic test_random_streams(int count);
		int target;
		int len0;
		int ntok;
		int k;
		target = items_sent + count;
		while (items_sent < target) begin
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(rand_weight(), rand_value(), 6'($urandom), 1'($urandom));
			end else begin
				len0 = pick_len();
				send_token(1'b1, len0);
				ntok = $urandom_range(1, 10);
				for (k = 0; k < ntok; k++)
					send_token(1'b0, ($urandom_range(0, 3) == 0) ? pick_len() : len0);
			end
		end
		calm = 1'b0;
	endtask

	initial begin : sink
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_means.size() == 0) begin
				$display("%0t: mean_out transfer with none expected, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_means.pop_front();
				if (m_tdata[MEAN_W-1:0] !== want) begin
					$display("%0t: mean_out expected %h actual %h", $time, want,
						m_tdata[MEAN_W-1:0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_start();
		test_zero_divisor();
		test_skipped_entries();
		test_rounding();
		set_epsilon(16'hFFFF);
		test_random_streams(215);
		set_epsilon('0);
		test_random_streams(215);
		set_epsilon(16'($urandom));
		test_random_streams(215);
		set_epsilon(EPS_RESET);
		test_random_streams(205);
		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("causal_weighted_prefix_mean_core: match");
		end else begin
			$display("causal_weighted_prefix_mean_core: mismatch");
		end
		$finish;
	end

endmodule
